FILE: rtl/rkcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkcs_pkg
// Shared types and constants of the rolling k-mer code scanner: the input and
// output words, the job word between front and back, and register indexes.
// ----------------------------------------------------------------------------
package rkcs_pkg;

    // field widths fixed by the interface
    localparam int BASE_BITS  = 2;
    localparam int KMER_BITS  = 6;
    localparam int CODE_BITS  = 64;
    localparam int POS_BITS   = 32;
    localparam int LEN_BITS   = 32;
    localparam int CFG_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_KMER_SIZE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_MATCH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EMIT_ALL  = 2'd2;

    // configuration reset values
    localparam logic [KMER_BITS-1:0] KMER_SIZE_RESET = 6'd32;
    localparam logic [LEN_BITS-1:0]  MIN_MATCH_RESET = 32'd32;

    // complement of a 2-bit base is its bitwise inverse
    localparam logic [BASE_BITS-1:0] BASE_COMPLEMENT = 2'b11;

    // input word
    typedef struct packed {
        logic [BASE_BITS-1:0] base;
        logic                 first_of_segment;
        logic [LEN_BITS-1:0]  segment_length;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [CODE_BITS-1:0] kmer_code;
        logic [POS_BITS-1:0]  relative_position;
        logic                 reverse_strand;
        logic                 needs_mark_check;
        logic                 last;
    } t_out_word;

    // classified base waiting for the back end
    typedef struct packed {
        logic [CODE_BITS-1:0] fwd_code;
        logic [CODE_BITS-1:0] rev_code;
        logic [POS_BITS-1:0]  fwd_pos;
        logic [POS_BITS-1:0]  rev_pos;
        logic                 emit_fwd;
        logic                 emit_rev;
        logic                 mark_check;
    } t_job;

endpackage
`default_nettype wire

FILE: rtl/rolling_kmer_code_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_kmer_code_scanner
// Streams 2-bit bases and emits forward and reverse-complement k-mer codes
// with their relative positions inside the current segment.
// ----------------------------------------------------------------------------
// Usage
//   input channel: one base word per transfer (i_valid / o_stall), with the
//     segment-start flag and the segment length taken on the first base.
//   output channel: zero, one or two code words per base (o_valid / i_stall),
//     forward code first; the last word of a base carries last = 1.
//   configuration: i_cfg_valid / o_cfg_ready writes k-mer size, minimum match
//     length and the emit-all flag; o_cfg_ready is always high, write only
//     when idle.
// Path: front rolling registers, then a queue slot, then the output register.
// Throughput: one word per cycle on the output register while i_stall is low;
//   a base with two codes sends its forward word, then its reverse word; the
//   single output register and its two-step forward/reverse sequence set this.
// A two-entry job queue between classifier and output keeps bases flowing
//   while a finished word waits; bases with no codes take no queue slot.
// Reset: clears codes, base count, segment length and all valid flags, and
//   loads k-mer size 32, minimum match 32, emit-all 0.
// Receiver stall: the output word holds; once the queue is full and the pending base has codes, o_stall rises.
// ----------------------------------------------------------------------------
module rolling_kmer_code_scanner
    import rkcs_pkg::*;
#(
    parameter int MAX_KMER      = 32,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input word channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire t_in_word                i_in,
    // output word channel
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output t_out_word                    o_out,
    // configuration write channel
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data
);

    logic push;
    t_job push_job;
    logic queue_full;
    logic pop;
    logic not_empty;
    t_job head;

    assign o_cfg_ready = 1'b1;

    // front: rolling codes and classification
    rkcs_front #(
        .MAX_KMER      (MAX_KMER),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in         (i_in),
        .i_cfg_write  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_push_job   (push_job),
        .i_queue_full (queue_full)
    );

    // job queue between front and back
    rkcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_job  (push_job),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_head      (head)
    );

    // back: word sequencing and output register
    rkcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (not_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

FILE: rtl/rkcs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkcs_queue
// Small register queue of jobs between the front and back of the scanner.
// ----------------------------------------------------------------------------
module rkcs_queue
    import rkcs_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_push_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_not_empty,
    output t_job      o_head
);

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);
    localparam logic [PtrBits-1:0] LastSlot = PtrBits'(DEPTH - 1);
    localparam logic [CntBits-1:0] FullCount = CntBits'(DEPTH);

    t_job               r_slot [DEPTH];
    logic [PtrBits-1:0] r_wr_ptr;
    logic [PtrBits-1:0] r_rd_ptr;
    logic [CntBits-1:0] r_count;

    assign o_full      = (r_count == FullCount);
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_slot[r_rd_ptr];

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastSlot) ? '0 : r_wr_ptr + PtrBits'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastSlot) ? '0 : r_rd_ptr + PtrBits'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntBits'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CntBits'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/rkcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkcs_front
// Front end: accepts bases, rolls the forward and reverse-complement codes,
// counts bases of the segment and classifies which codes are emitted.
// ----------------------------------------------------------------------------
module rkcs_front
    import rkcs_pkg::*;
#(
    parameter int MAX_KMER      = 32,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input word channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire t_in_word                i_in,
    // configuration writes
    input  wire logic                    i_cfg_write,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data,
    // job queue push side
    output logic                         o_push,
    output t_job                         o_push_job,
    input  wire logic                    i_queue_full
);

    localparam logic [KMER_BITS-1:0] MaxKmer = KMER_BITS'(MAX_KMER);
    localparam logic [POS_BITS-1:0]  PosMask = (POSITION_BITS >= POS_BITS) ? '1 :
        POS_BITS'((64'd1 << POSITION_BITS) - 64'd1);

    // configuration
    logic [KMER_BITS-1:0] r_kmer_size;
    logic [LEN_BITS-1:0]  r_min_match;
    logic                 r_emit_all;

    // rolling state, also the payload of the classify stage
    logic [CODE_BITS-1:0] r_fwd_code, n_fwd_code;
    logic [CODE_BITS-1:0] r_rev_code, n_rev_code;
    logic [LEN_BITS-1:0]  r_seen, n_seen;
    logic [LEN_BITS-1:0]  r_len, n_len;
    logic                 r_pending;

    logic [KMER_BITS-1:0] k_eff;
    logic [CODE_BITS-1:0] code_mask;
    logic [6:0]           rev_shift;
    logic [CODE_BITS-1:0] fwd_base, rev_base;
    logic [LEN_BITS-1:0]  seen_base;
    logic [LEN_BITS-1:0]  k_wide;
    logic [LEN_BITS:0]    fwd_lhs, fwd_rhs;
    logic                 in_window;
    logic                 emit_fwd, emit_rev;
    logic                 advance;
    logic                 accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_size <= KMER_SIZE_RESET;
            r_min_match <= MIN_MATCH_RESET;
            r_emit_all  <= 1'b0;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_KMER_SIZE: r_kmer_size <= i_cfg_data[KMER_BITS-1:0];
                CFG_MIN_MATCH: r_min_match <= i_cfg_data[LEN_BITS-1:0];
                CFG_EMIT_ALL:  r_emit_all  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective k-mer size and code mask
    always_comb begin
        priority if (r_kmer_size == '0) begin
            k_eff = KMER_BITS'(1);
        end else if (r_kmer_size > MaxKmer) begin
            k_eff = MaxKmer;
        end else begin
            k_eff = r_kmer_size;
        end
        code_mask = (k_eff >= KMER_BITS'(32)) ? '1 :
            ((CODE_BITS'(1) << {k_eff, 1'b0}) - CODE_BITS'(1));
        rev_shift = {k_eff - KMER_BITS'(1), 1'b0};
    end

    // rolling update for the incoming base
    always_comb begin
        fwd_base  = i_in.first_of_segment ? '0 : r_fwd_code;
        rev_base  = i_in.first_of_segment ? '0 : r_rev_code;
        seen_base = i_in.first_of_segment ? '0 : r_seen;
        n_len     = i_in.first_of_segment ? i_in.segment_length : r_len;
        n_fwd_code = {fwd_base[CODE_BITS-3:0], i_in.base} & code_mask;
        n_rev_code = (((rev_base & code_mask) >> 2)
            | ({{(CODE_BITS-BASE_BITS){1'b0}}, i_in.base ^ BASE_COMPLEMENT} << rev_shift))
            & code_mask;
        n_seen = (seen_base == '1) ? seen_base : seen_base + LEN_BITS'(1);
    end

    // classify the latest base: which strands emit
    always_comb begin
        k_wide    = {{(LEN_BITS-KMER_BITS){1'b0}}, k_eff};
        in_window = (r_len >= r_min_match) && (r_len >= k_wide)
                    && (r_seen >= k_wide) && (r_seen <= r_len);
        // forward position seen-k must not pass len-min_match
        fwd_lhs   = {1'b0, r_seen} + {1'b0, r_min_match};
        fwd_rhs   = {1'b0, r_len} + {1'b0, k_wide};
        emit_fwd  = in_window && (fwd_lhs <= fwd_rhs) && (r_emit_all || (r_seen > k_wide));
        // reverse position len-seen must not pass len-min_match
        emit_rev  = in_window && (r_seen >= r_min_match) && (r_emit_all || (r_seen < r_len));
    end

    assign o_push_job.fwd_code   = r_fwd_code;
    assign o_push_job.rev_code   = r_rev_code;
    assign o_push_job.fwd_pos    = (r_seen - k_wide) & PosMask;
    assign o_push_job.rev_pos    = (r_len - r_seen) & PosMask;
    assign o_push_job.emit_fwd   = emit_fwd;
    assign o_push_job.emit_rev   = emit_rev;
    assign o_push_job.mark_check = !r_emit_all;

    // handshake: a base with no codes retires without a queue slot
    assign advance = !r_pending || !((emit_fwd || emit_rev) && i_queue_full);
    assign o_stall = !advance;
    assign accept  = i_valid && advance;
    assign o_push  = r_pending && (emit_fwd || emit_rev) && !i_queue_full;

    // rolling state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_code <= '0;
            r_rev_code <= '0;
            r_seen     <= '0;
            r_len      <= '0;
            r_pending  <= 1'b0;
        end else begin
            if (accept) begin
                r_fwd_code <= n_fwd_code;
                r_rev_code <= n_rev_code;
                r_seen     <= n_seen;
                r_len      <= n_len;
                r_pending  <= 1'b1;
            end else if (advance) begin
                r_pending  <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/rkcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkcs_back
// Back end: takes jobs from the queue and sends the forward code, then the
// reverse-complement code, through a registered output word.
// ----------------------------------------------------------------------------
module rkcs_back
    import rkcs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // job queue pop side
    input  wire logic i_not_empty,
    input  wire t_job i_head,
    output logic      o_pop,
    // output word channel
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out_word o_out
);

    logic      r_out_valid;
    t_out_word r_out;
    logic      r_rev_phase;

    logic load;
    logic sel_rev;
    logic final_word;

    // pick the strand for the next word of the head job
    assign load       = i_not_empty && (!r_out_valid || !i_stall);
    assign sel_rev    = r_rev_phase || !i_head.emit_fwd;
    assign final_word = sel_rev || !i_head.emit_rev;
    assign o_pop      = load && final_word;

    // output word register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.kmer_code         <= sel_rev ? i_head.rev_code : i_head.fwd_code;
            r_out.relative_position <= sel_rev ? i_head.rev_pos : i_head.fwd_pos;
            r_out.reverse_strand    <= sel_rev;
            r_out.needs_mark_check  <= i_head.mark_check;
            r_out.last              <= final_word;
        end
    end

    // valid and strand phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rev_phase <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_rev_phase <= !final_word;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule
`default_nettype wire
